@@ rtl/eap_pkg.sv @@
// Package for the element-wise add, ReLU and pool block.
// Holds sizes, register indexes, configuration and controller/datapath types.
// Used by eap_ctrl, eap_dp and eltwise_add_relu_pool.
package eap_pkg;

  localparam int LANES      = 8;
  localparam int POOL_ITEMS = 49;
  localparam int LANE_W     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W      = (POOL_ITEMS > 1) ? $clog2(POOL_ITEMS) : 1;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_ROW_WIDTH  = 3'd1;
  localparam logic [2:0] REG_PLANE_SIZE = 3'd2;
  localparam logic [2:0] REG_STEP       = 3'd3;
  localparam logic [2:0] REG_POOL_GAIN  = 3'd4;
  localparam logic [2:0] REG_SCALE_A    = 3'd5;
  localparam logic [2:0] REG_SCALE_B    = 3'd6;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_NONE   = 2'd1;
  localparam logic [1:0] MODE_STRIDE = 2'd2;
  localparam logic [1:0] MODE_POOL   = 2'd3;

  localparam logic [6:0] OUT_MAX = 7'd127;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  row_width;
    logic [23:0] plane_size;
    logic [7:0]  step;
    logic [15:0] pool_gain;
    logic [23:0] scale_a;
    logic [23:0] scale_b;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              walk_cmp;
    logic              lane_mul;
    logic              lane_sum;
    logic              pool_lo;
    logic              pool_hi;
    logic              pool_fin;
    logic              upd_col;
    logic              upd_plane;
    logic              finish;
    logic [LANE_W-1:0] lane;
  } cmd_t;

  typedef struct packed {
    logic walk_hit;
    logic pool_hit;
    logic emit;
    logic out_full;
  } sts_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_WALK   = 10'b00_0000_0010,
    ST_LMUL   = 10'b00_0000_0100,
    ST_LSUM   = 10'b00_0000_1000,
    ST_PLO    = 10'b00_0001_0000,
    ST_PHI    = 10'b00_0010_0000,
    ST_PFIN   = 10'b00_0100_0000,
    ST_UCOL   = 10'b00_1000_0000,
    ST_UPLANE = 10'b01_0000_0000,
    ST_FIN    = 10'b10_0000_0000
  } state_e;

endpackage

@@ rtl/eap_ctrl.sv @@
// Controller state machine of the element-wise add, ReLU and pool block.
// Sequences lanes, pool output and walk update; depends on eap_pkg.
module eap_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  eap_pkg::sts_t sts_i,
  output eap_pkg::cmd_t cmd_o
);
  import eap_pkg::*;

  state_e            state_q, state_d;
  logic [LANE_W-1:0] lane_q, lane_d;
  logic              last_lane;

  assign last_lane  = (lane_q == LANE_W'(LANES - 1));
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    lane_d  = lane_q;
    cmd_o   = '0;
    cmd_o.lane = lane_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          lane_d     = '0;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.walk_cmp = 1'b1;
        state_d        = ST_LMUL;
      end
      ST_LMUL: begin
        cmd_o.lane_mul = 1'b1;
        state_d        = ST_LSUM;
      end
      ST_LSUM: begin
        cmd_o.lane_sum = 1'b1;
        if (last_lane) begin
          lane_d = '0;
          if (sts_i.pool_hit) begin
            state_d = ST_PLO;
          end else if (sts_i.walk_hit) begin
            state_d = ST_UCOL;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          lane_d  = lane_q + 1'b1;
          state_d = ST_LMUL;
        end
      end
      ST_PLO: begin
        cmd_o.pool_lo = 1'b1;
        state_d       = ST_PHI;
      end
      ST_PHI: begin
        cmd_o.pool_hi = 1'b1;
        state_d       = ST_PFIN;
      end
      ST_PFIN: begin
        cmd_o.pool_fin = 1'b1;
        if (last_lane) begin
          lane_d  = '0;
          state_d = ST_FIN;
        end else begin
          lane_d  = lane_q + 1'b1;
          state_d = ST_PLO;
        end
      end
      ST_UCOL: begin
        cmd_o.upd_col = 1'b1;
        state_d       = ST_UPLANE;
      end
      ST_UPLANE: begin
        cmd_o.upd_plane = 1'b1;
        state_d         = ST_FIN;
      end
      ST_FIN: begin
        if (!(sts_i.emit && sts_i.out_full)) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lane_q  <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
    end
  end

endmodule

@@ rtl/eap_dp.sv @@
// Datapath of the element-wise add, ReLU and pool block: lane multiply,
// accumulators, pool scaling, strided walk counters and output register.
// Depends on eap_pkg; driven by eap_ctrl.
module eap_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  eap_pkg::cfg_t cfg_i,
  input  eap_pkg::cmd_t cmd_i,
  output eap_pkg::sts_t sts_o,
  input  logic [63:0]   lanes_a_i,
  input  logic [63:0]   lanes_b_i,
  input  logic          last_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [63:0]   lanes_out_o
);
  import eap_pkg::*;

  logic [63:0]        a_q, b_q;
  logic               last_q;
  logic signed [31:0] pa_q, pb_q;
  logic [39:0]        pl_q, ph_q;
  logic [47:0]        acc_q [LANES];
  logic [7:0]         res_q [LANES];
  logic [31:0]        item_q, row_q, plane_q;
  logic [8:0]         col_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [15:0]        stepw_q;
  logic               hit_q, wrap_q;
  logic               out_valid_q;
  logic [63:0]        out_q;

  logic signed [7:0]  a_lane, b_lane;
  logic signed [32:0] sum;
  logic [31:0]        relu;
  logic [16:0]        rnd;
  logic [7:0]         lane_res;
  logic [63:0]        tot;
  logic [7:0]         pool_res;
  logic [8:0]         col_n;
  logic               pool_hit, walk_hit, emit;
  logic [63:0]        packed_res;

  assign a_lane   = a_q[8*cmd_i.lane +: 8];
  assign b_lane   = b_q[8*cmd_i.lane +: 8];
  assign sum      = 33'(pa_q) + 33'(pb_q);
  assign relu     = sum[32] ? 32'd0 : sum[31:0];
  assign rnd      = 17'((33'(relu) + 33'h0_0000_8000) >> 16);
  assign lane_res = (rnd > 17'(OUT_MAX)) ? {1'b0, OUT_MAX} : {1'b0, rnd[6:0]};
  assign tot      = {ph_q, 24'd0} + 64'(pl_q) + 64'h0000_0000_8000_0000;
  assign pool_res = (tot[63:32] > 32'(OUT_MAX)) ? {1'b0, OUT_MAX} : {1'b0, tot[38:32]};
  assign col_n    = col_q + 9'(cfg_i.step);

  assign pool_hit = (cfg_i.mode == MODE_POOL) && (cnt_q == CNT_W'(POOL_ITEMS - 1));
  assign walk_hit = (cfg_i.mode == MODE_STRIDE) && hit_q;
  assign emit     = (cfg_i.mode == MODE_PLAIN) || walk_hit || pool_hit;

  assign sts_o.walk_hit = walk_hit;
  assign sts_o.pool_hit = pool_hit;
  assign sts_o.emit     = emit;
  assign sts_o.out_full = out_valid_q && !out_ready_i;

  always_comb begin
    packed_res = '0;
    for (int i = 0; i < LANES; i++) begin
      packed_res[8*i +: 8] = res_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= lanes_a_i;
      b_q    <= lanes_b_i;
      last_q <= last_item_i;
    end
    if (cmd_i.lane_mul) begin
      pa_q <= a_lane * $signed(cfg_i.scale_a);
      pb_q <= b_lane * $signed(cfg_i.scale_b);
    end
    if (cmd_i.lane_sum && cfg_i.mode != MODE_POOL) begin
      res_q[cmd_i.lane] <= lane_res;
    end
    if (cmd_i.pool_lo) begin
      pl_q <= acc_q[cmd_i.lane][23:0] * cfg_i.pool_gain;
    end
    if (cmd_i.pool_hi) begin
      ph_q <= acc_q[cmd_i.lane][47:24] * cfg_i.pool_gain;
    end
    if (cmd_i.pool_fin) begin
      res_q[cmd_i.lane] <= pool_res;
    end
    if (cmd_i.walk_cmp) begin
      stepw_q <= cfg_i.step * cfg_i.row_width;
    end
    if (cmd_i.finish && emit) begin
      out_q <= packed_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        acc_q[i] <= '0;
      end
    end else if (cmd_i.finish && last_q) begin
      for (int i = 0; i < LANES; i++) begin
        acc_q[i] <= '0;
      end
    end else if (cmd_i.lane_sum && cfg_i.mode == MODE_POOL) begin
      acc_q[cmd_i.lane] <= acc_q[cmd_i.lane] + 48'(relu);
    end else if (cmd_i.pool_fin) begin
      acc_q[cmd_i.lane] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      plane_q     <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.walk_cmp) begin
        hit_q <= ((plane_q + row_q + 32'(col_q)) == item_q);
      end
      if (cmd_i.upd_col) begin
        if (col_n >= 9'(cfg_i.row_width)) begin
          col_q  <= '0;
          row_q  <= row_q + 32'(stepw_q);
          wrap_q <= 1'b1;
        end else begin
          col_q  <= col_n;
          wrap_q <= 1'b0;
        end
      end
      if (cmd_i.upd_plane && wrap_q && row_q >= 32'(cfg_i.plane_size)) begin
        row_q   <= '0;
        plane_q <= plane_q + 32'(cfg_i.plane_size);
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          item_q  <= '0;
          col_q   <= '0;
          row_q   <= '0;
          plane_q <= '0;
          cnt_q   <= '0;
        end else begin
          item_q <= item_q + 32'd1;
          if (cfg_i.mode == MODE_POOL) begin
            cnt_q <= pool_hit ? '0 : cnt_q + 1'b1;
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign lanes_out_o = out_q;

endmodule

@@ rtl/eltwise_add_relu_pool.sv @@
// Top level of the element-wise int8 add with ReLU, subsample and average pool.
// Holds the configuration registers; instantiates eap_ctrl and eap_dp (eap_pkg).
//
// channel  dir  payload                                   handshake
// s_axis   in   tdata: lanes_a [63:0], lanes_b [127:64]   tvalid/tready
//               tlast: last_item
// m_axis   out  tdata: lanes_out [63:0]                   tvalid/tready
// cfg      in   cfg_addr_i register index, cfg_data_i     cfg_we_i
//
// An item passes through the accepting idle state, walk compare, a multiply and
// a sum step per lane on the shared pair of lane multipliers, then finish; a
// pool output adds a low, high and final step per lane (split 24x16 multiply)
// and a strided hit adds the column and plane walk update.
// Reset clears counters, accumulators and the output register valid.
// A result waits in the output register; only the next result stalls on it.
module eltwise_add_relu_pool (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // lanes_a [63:0], lanes_b [127:64]
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,   // lanes_out [63:0]
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_addr_i,
  input  logic [23:0]   cfg_data_i
);
  import eap_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= MODE_PLAIN;
      cfg_q.row_width  <= 8'd1;
      cfg_q.plane_size <= 24'd1;
      cfg_q.step       <= 8'd1;
      cfg_q.pool_gain  <= 16'd0;
      cfg_q.scale_a    <= 24'd65536;
      cfg_q.scale_b    <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_MODE:       cfg_q.mode       <= cfg_data_i[1:0];
        REG_ROW_WIDTH:  cfg_q.row_width  <= cfg_data_i[7:0];
        REG_PLANE_SIZE: cfg_q.plane_size <= cfg_data_i;
        REG_STEP:       cfg_q.step       <= cfg_data_i[7:0];
        REG_POOL_GAIN:  cfg_q.pool_gain  <= cfg_data_i[15:0];
        REG_SCALE_A:    cfg_q.scale_a    <= cfg_data_i;
        REG_SCALE_B:    cfg_q.scale_b    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  eap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eap_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .lanes_a_i   (s_axis_tdata[63:0]),
    .lanes_b_i   (s_axis_tdata[127:64]),
    .last_item_i (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .lanes_out_o (m_axis_tdata)
  );

endmodule
